// ===== src/trie_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trie_pkg
// Types and constants shared by the trie word matcher modules.
// ----------------------------------------------------------------------------
package trie_pkg;

	localparam int NODE_COUNT   = 8192;
	localparam int IDX_W        = $clog2(NODE_COUNT);
	localparam int ROOT_ENTRIES = 256;
	localparam int MAX_WORD_LEN = 32;
	localparam int WORD_IDS     = 32768;
	localparam int ID_W         = 15;
	localparam int LEN_W        = 6;
	localparam int POS_W        = 32;
	localparam int CHAR_W       = 8;
	localparam int FIELD_IDX_W  = 13;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_TEXT  = 1'b1;

	typedef struct packed {
		logic                   func;
		logic [FIELD_IDX_W-1:0] node_index;
		logic [CHAR_W-1:0]      node_char;
		logic [FIELD_IDX_W-1:0] node_parent;
		logic [FIELD_IDX_W-1:0] node_first_child;
		logic [ID_W-1:0]        node_word_id;
		logic [LEN_W-1:0]       node_word_len;
		logic [CHAR_W-1:0]      text_byte;
		logic                   last_byte;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0] hit_start;
		logic [ID_W-1:0]  hit_word_id;
		logic [LEN_W-1:0] hit_len;
	} hit_t;

	// one trie table entry
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  parent;
		logic [IDX_W-1:0]  child;
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
	} entry_t;

	// classified word handed from front to back
	typedef struct packed {
		logic              is_text;
		logic              in_range;
		logic [IDX_W-1:0]  index;
		entry_t            node;
		logic [CHAR_W-1:0] ch;
		logic              alpha;
		logic              last;
	} qitem_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} back_status_t;

endpackage
`default_nettype wire

// ===== src/trie_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trie_front
// Accepts words, folds case and tags letters, and queues them for the back.
// ----------------------------------------------------------------------------
module trie_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire trie_pkg::req_t        req,
	input  wire trie_pkg::back_status_t st,
	output logic                       head_valid,
	output trie_pkg::qitem_t           head
);

	trie_pkg::qitem_t ent_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	trie_pkg::qitem_t item;
	logic             push;
	logic             upper;
	logic             lower;

	always_comb begin
		upper = (req.text_byte >= 8'h41) && (req.text_byte <= 8'h5a);
		lower = (req.text_byte >= 8'h61) && (req.text_byte <= 8'h7a);
		item.is_text     = (req.func == trie_pkg::FUNC_TEXT);
		item.in_range    = 32'(req.node_index) < trie_pkg::NODE_COUNT;
		item.index       = req.node_index[trie_pkg::IDX_W-1:0];
		item.node.ch     = req.node_char;
		item.node.parent = req.node_parent[trie_pkg::IDX_W-1:0];
		item.node.child  = req.node_first_child[trie_pkg::IDX_W-1:0];
		item.node.id     = req.node_word_id & trie_pkg::ID_W'(trie_pkg::WORD_IDS - 1);
		item.node.len    = req.node_word_len;
		item.ch          = upper ? (req.text_byte + 8'd32) : req.text_byte;
		item.alpha       = upper || lower;
		item.last        = req.last_byte;
	end

	assign req_stall  = (cnt_q == 2'd2) || st.clearing;
	assign push       = req_valid && !req_stall;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (st.pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(st.pop);
		end
	end

endmodule
`default_nettype wire

// ===== src/trie_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trie_back
// Scan engine: trie table memory, sibling walk sequencer and result register.
// ----------------------------------------------------------------------------
module trie_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire trie_pkg::qitem_t head,
	output trie_pkg::back_status_t st,
	output logic                  hit_valid,
	input  wire logic             hit_stall,
	output trie_pkg::hit_t        hit
);

	localparam int IW = trie_pkg::IDX_W;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_CHILD, ST_WALK, ST_ROOT, ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MODE_SEEK  = 2'd0,
		MODE_MATCH = 2'd1,
		MODE_SKIP  = 2'd2
	} mode_t;

	trie_pkg::entry_t mem [trie_pkg::NODE_COUNT];
	trie_pkg::entry_t rd_q;
	logic [IW-1:0]    rd_addr;
	logic             we;
	logic [IW-1:0]    wa;
	trie_pkg::entry_t wd;

	state_t                       state_q;
	mode_t                        mode_q;
	logic [IW-1:0]                clr_q;
	logic [IW-1:0]                cur_q;
	logic [IW-1:0]                s_q;
	logic [trie_pkg::POS_W-1:0]   start_q;
	logic [trie_pkg::POS_W-1:0]   pos_q;
	logic [trie_pkg::LEN_W-1:0]   depth_q;
	logic                         pend_q;
	logic [trie_pkg::ID_W-1:0]    pend_id_q;
	logic [trie_pkg::LEN_W-1:0]   pend_len_q;
	logic [trie_pkg::CHAR_W-1:0]  c_q;
	logic                         alpha_q;
	logic                         last_q;
	logic                         res_v_q;
	trie_pkg::hit_t               res_q;
	logic                         hit_valid_q;
	trie_pkg::hit_t               hit_q;

	logic                        pop;
	logic [IW-1:0]               root_head;
	logic [IW-1:0]               root_c;
	logic                        sib;
	logic                        found;
	logic                        more;
	logic [trie_pkg::LEN_W-1:0]  depth_nx;
	logic                        out_free;

	function automatic logic hit_ok(trie_pkg::entry_t e, logic [trie_pkg::LEN_W-1:0] d);
		hit_ok = (e.id != '0) && (e.len != '0)
			&& (32'(e.len) <= trie_pkg::MAX_WORD_LEN) && (e.len == d);
	endfunction

	always_comb begin
		pop       = (state_q == ST_IDLE) && head_valid;
		root_head = IW'(head.ch);
		root_c    = IW'(c_q);
		sib       = (rd_q.parent == cur_q);
		found     = sib && (rd_q.ch == c_q);
		more      = sib && (32'(s_q) != trie_pkg::NODE_COUNT - 1);
		depth_nx  = (depth_q != '1) ? depth_q + 1'b1 : depth_q;
		out_free  = !hit_valid_q || !hit_stall;
		rd_addr   = cur_q;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = (mode_q == MODE_MATCH) ? cur_q : root_head;
			end
			ST_CHILD: begin
				rd_addr = (rd_q.child != '0) ? rd_q.child : root_c;
			end
			ST_WALK: begin
				rd_addr = more ? s_q + 1'b1 : root_c;
			end
			default: begin
				rd_addr = cur_q;
			end
		endcase
		we = 1'b0;
		wa = head.index;
		wd = head.node;
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
			wa = clr_q;
			wd = '0;
		end else if (pop && !head.is_text && head.in_range) begin
			we = 1'b1;
		end
	end

	assign st.clearing = (state_q == ST_CLEAR);
	assign st.pop      = pop;
	assign hit_valid   = hit_valid_q;
	assign hit         = hit_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			mode_q      <= MODE_SEEK;
			clr_q       <= '0;
			cur_q       <= '0;
			s_q         <= '0;
			start_q     <= '0;
			pos_q       <= '0;
			depth_q     <= '0;
			pend_q      <= 1'b0;
			pend_id_q   <= '0;
			pend_len_q  <= '0;
			c_q         <= '0;
			alpha_q     <= 1'b0;
			last_q      <= 1'b0;
			res_v_q     <= 1'b0;
			res_q       <= '0;
			hit_valid_q <= 1'b0;
			hit_q       <= '0;
		end else begin
			if (hit_valid_q && !hit_stall) begin
				hit_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop && head.is_text) begin
						c_q     <= head.ch;
						alpha_q <= head.alpha;
						last_q  <= head.last;
						// pending hit is confirmed by a non-letter
						res_v_q           <= pend_q && !head.alpha;
						res_q.hit_start   <= start_q;
						res_q.hit_word_id <= pend_id_q;
						res_q.hit_len     <= pend_len_q;
						pend_q            <= 1'b0;
						if (mode_q == MODE_MATCH) begin
							state_q <= ST_CHILD;
						end else if (mode_q == MODE_SKIP && head.alpha) begin
							state_q <= ST_DONE;
						end else begin
							mode_q  <= MODE_SEEK;
							state_q <= ST_ROOT;
						end
					end
				end
				ST_CHILD: begin
					if (rd_q.child != '0) begin
						s_q     <= rd_q.child;
						state_q <= ST_WALK;
					end else if (alpha_q) begin
						mode_q  <= MODE_SKIP;
						state_q <= ST_DONE;
					end else begin
						mode_q  <= MODE_SEEK;
						state_q <= ST_ROOT;
					end
				end
				ST_WALK: begin
					if (found) begin
						cur_q   <= s_q;
						depth_q <= depth_nx;
						state_q <= ST_DONE;
						if (hit_ok(rd_q, depth_nx)) begin
							if (last_q) begin
								res_v_q           <= 1'b1;
								res_q.hit_start   <= start_q;
								res_q.hit_word_id <= rd_q.id;
								res_q.hit_len     <= rd_q.len;
							end else begin
								pend_q     <= 1'b1;
								pend_id_q  <= rd_q.id;
								pend_len_q <= rd_q.len;
							end
						end
					end else if (more) begin
						s_q <= s_q + 1'b1;
					end else if (alpha_q) begin
						mode_q  <= MODE_SKIP;
						state_q <= ST_DONE;
					end else begin
						mode_q  <= MODE_SEEK;
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					state_q <= ST_DONE;
					if (rd_q.id != '0) begin
						mode_q  <= MODE_MATCH;
						start_q <= pos_q;
						cur_q   <= root_c;
						depth_q <= trie_pkg::LEN_W'(1);
						if (hit_ok(rd_q, trie_pkg::LEN_W'(1))) begin
							if (last_q) begin
								res_v_q           <= 1'b1;
								res_q.hit_start   <= pos_q;
								res_q.hit_word_id <= rd_q.id;
								res_q.hit_len     <= rd_q.len;
							end else begin
								pend_q     <= 1'b1;
								pend_id_q  <= rd_q.id;
								pend_len_q <= rd_q.len;
							end
						end
					end
				end
				ST_DONE: begin
					if (!res_v_q || out_free) begin
						if (res_v_q) begin
							hit_valid_q <= 1'b1;
							hit_q       <= res_q;
						end
						if (last_q) begin
							pos_q  <= '0;
							mode_q <= MODE_SEEK;
							pend_q <= 1'b0;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/trie_dictionary_word_matcher_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// a node write is stored as idle pops it; a byte in seek steps idle, root, done; a skipped
// letter idle, done; match idle, child, walk per sibling, done (root first on non-letter miss)
// throughput: one byte at a time, set by the single read port of the trie table
// reset: after arst_n the table's 8192 entries are cleared one entry a cycle,
// during which no word is accepted
// ----------------------------------------------------------------------------
// trie_dictionary_word_matcher_top
// Dictionary word matcher over a trie table with front queue and scan engine.
// ----------------------------------------------------------------------------
module trie_dictionary_word_matcher_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire trie_pkg::req_t req,
	output logic                hit_valid,
	input  wire logic           hit_stall,
	output trie_pkg::hit_t      hit
);

	trie_pkg::back_status_t st;
	logic                   head_valid;
	trie_pkg::qitem_t       head;

	trie_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.st         (st),
		.head_valid (head_valid),
		.head       (head)
	);

	trie_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.st         (st),
		.hit_valid  (hit_valid),
		.hit_stall  (hit_stall),
		.hit        (hit)
	);

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		st.clearing |-> req_stall)
		else $error("word accepted during table clear");

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		st.pop |-> head_valid)
		else $error("queue popped while empty");

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		st.clearing |-> !st.pop)
		else $error("queue popped during table clear");

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the trie word matcher: loads small random tries, streams text
// built from dictionary words and noise, and checks hits against a predictor.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [1:0] SCAN_SEEK  = 2'd0;
	localparam logic [1:0] SCAN_MATCH = 2'd1;
	localparam logic [1:0] SCAN_SKIP  = 2'd2;
	localparam int IDLE_LIMIT = 40000;

	class hit_scoreboard;
		trie_pkg::entry_t tbl[trie_pkg::NODE_COUNT];
		logic [1:0]       mode;
		logic [12:0]      cur;
		logic [31:0]      start_pos;
		logic [5:0]       depth;
		logic [31:0]      pos;
		logic             pend;
		logic [14:0]      pend_id;
		logic [5:0]       pend_len;
		trie_pkg::hit_t   expq[$];
		int               errors;

		function void clear();
			foreach (tbl[i]) tbl[i] = '0;
			mode = SCAN_SEEK; cur = 0; start_pos = 0; depth = 0; pos = 0;
			pend = 0; pend_id = 0; pend_len = 0; errors = 0;
		endfunction

		function void word_hit(logic [12:0] n, logic last, ref logic got,
				ref trie_pkg::hit_t h);
			if (tbl[n].id == 0 || tbl[n].len == 0 || tbl[n].len > trie_pkg::MAX_WORD_LEN
					|| tbl[n].len != depth)
				return;
			if (last) begin
				got = 1; h = '{start_pos, tbl[n].id, tbl[n].len};
			end else begin
				pend = 1; pend_id = tbl[n].id; pend_len = tbl[n].len;
			end
		endfunction

		function void note_word(trie_pkg::req_t r);
			logic [7:0] b, c;
			logic alpha, got, found, finished;
			logic [13:0] s;
			trie_pkg::hit_t h;
			if (r.func == trie_pkg::FUNC_WRITE) begin
				tbl[r.node_index] = '{r.node_char, r.node_parent, r.node_first_child,
					r.node_word_id, r.node_word_len};
				return;
			end
			b = r.text_byte;
			alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
			c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
			got = 0; finished = 0; h = '0;
			if (pend && !alpha) begin
				got = 1; h = '{start_pos, pend_id, pend_len};
			end
			pend = 0;
			if (mode == SCAN_MATCH) begin
				found = 0;
				s = tbl[cur].child;
				if (s != 0)
					while (s < trie_pkg::NODE_COUNT && tbl[s].parent == cur) begin
						if (tbl[s].ch == c) begin
							found = 1;
							break;
						end
						s++;
					end
				if (found) begin
					cur = s[12:0];
					if (depth < 63) depth++;
					word_hit(cur, r.last_byte, got, h);
					finished = 1;
				end else
					mode = SCAN_SKIP;
			end
			if (!finished && mode == SCAN_SKIP) begin
				if (alpha) finished = 1;
				else mode = SCAN_SEEK;
			end
			if (!finished && mode != SCAN_MATCH && mode != SCAN_SKIP)
				if (tbl[c].id != 0) begin
					mode = SCAN_MATCH; start_pos = pos; cur = {5'd0, c}; depth = 1;
					word_hit(cur, r.last_byte, got, h);
				end
			if (r.last_byte) begin
				pos = 0; mode = SCAN_SEEK; pend = 0;
			end else
				pos++;
			if (got) expq.push_back(h);
		endfunction

		function void check_hit(trie_pkg::hit_t h);
			trie_pkg::hit_t e;
			if (expq.size() == 0) begin
				$display("%0t: unexpected hit exp none got %h", $time, h);
				errors++;
				return;
			end
			e = expq.pop_front();
			if (e.hit_start != h.hit_start) begin
				$display("%0t: start exp %0d got %0d", $time, e.hit_start, h.hit_start);
				errors++;
			end
			if (e.hit_word_id != h.hit_word_id) begin
				$display("%0t: id exp %0d got %0d", $time, e.hit_word_id, h.hit_word_id);
				errors++;
			end
			if (e.hit_len != h.hit_len) begin
				$display("%0t: len exp %0d got %0d", $time, e.hit_len, h.hit_len);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, req_valid, req_stall, hit_valid;
	logic hit_stall = 1'b0;
	trie_pkg::req_t req;
	trie_pkg::hit_t hit;
	int send_idle, recv_idle;
	int idle_cycles = 0;
	hit_scoreboard sb;
	// dictionary kept for building text
	string dict[$];

	trie_dictionary_word_matcher_top dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.req(req), .hit_valid(hit_valid), .hit_stall(hit_stall), .hit(hit)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (req_valid && !req_stall) sb.note_word(req);
		if (hit_valid && !hit_stall) sb.check_hit(hit);
		if ((req_valid && !req_stall) || (hit_valid && !hit_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		hit_stall <= ($urandom_range(99) < recv_idle);
		if (idle_cycles > IDLE_LIMIT) begin
			$display("[trie_dictionary_word_matcher_top] ERROR");
			$finish;
		end
	end

	// valid stays up after a word until the next word or an idle cycle drops it
	task automatic send_word(trie_pkg::req_t r);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic write_node(int idx, int ch, int par, int kid, int id, int len);
		trie_pkg::req_t r;
		logic [95:0] noise;
		noise = {$urandom(), $urandom(), $urandom()};
		r = noise[$bits(trie_pkg::req_t)-1:0];
		r.func = trie_pkg::FUNC_WRITE;
		r.node_index = 13'(idx); r.node_char = 8'(ch); r.node_parent = 13'(par);
		r.node_first_child = 13'(kid); r.node_word_id = 15'(id);
		r.node_word_len = 6'(len);
		send_word(r);
	endtask

	task automatic text_byte(int b, bit last);
		trie_pkg::req_t r;
		logic [95:0] noise;
		noise = {$urandom(), $urandom(), $urandom()};
		r = noise[$bits(trie_pkg::req_t)-1:0];
		r.func = trie_pkg::FUNC_TEXT;
		r.text_byte = 8'(b); r.last_byte = last;
		send_word(r);
	endtask

	task automatic drain();
		req_valid <= 0;
		while (sb.expq.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// small trie: roots a,b,c with four two-letter entries beneath each
	task automatic build_trie();
		int base, id;
		string w;
		dict.delete();
		id = 1 + $urandom_range(30000);
		base = 300 + $urandom_range(7000);
		for (int r = 0; r < 3; r++) begin
			write_node("a" + r, "a" + r, 0, base + 4 * r, ($urandom_range(3) == 0) ? 0 : id + r,
				1 + (r == 2));
			for (int k = 0; k < 4; k++) begin
				write_node(base + 4 * r + k, "a" + k + $urandom_range(1), "a" + r, 0,
					($urandom_range(4) == 0) ? 0 : id + 10 + 4 * r + k, 2);
				w = "xx";
				w[0] = "a" + r;
				dict.push_back(w);
			end
		end
	endtask

	task automatic random_text(int n);
		string w;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: text_byte($urandom_range(255), $urandom_range(15) == 0);
				1: text_byte(" ", 0);
				default: begin
					w = dict[$urandom_range(dict.size() - 1)];
					text_byte(($urandom_range(1) ? w[0] - 32 : w[0]), 0);
					text_byte("a" + $urandom_range(4), $urandom_range(7) == 0);
					if ($urandom_range(1)) text_byte("a" + $urandom_range(2), 0);
					text_byte($urandom_range(2) ? "." : "z", $urandom_range(5) == 0);
				end
			endcase
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		arst_n = 0; req_valid = 0; req = '0;
		send_idle = 28; recv_idle = 57;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		// directed: extremes, table end, last-byte hits
		write_node(8191, 8'hff, 8191, 8191, 32767, 63);
		write_node("q", "q", 0, 8190, 5, 1);
		write_node(8190, "u", "q", 0, 32767, 2);
		write_node(8191, "x", "q", 0, 6, 2);
		write_node("z", "z", 0, 0, 0, 1);
		write_node(8'hff, 8'hff, 0, 0, 9, 1);
		text_byte("Q", 0); text_byte("u", 0); text_byte(" ", 0);
		text_byte("q", 0); text_byte("x", 1);
		text_byte("q", 1);
		text_byte("q", 0); text_byte("w", 0); text_byte("!", 0); text_byte("q", 0);
		text_byte(8'hff, 0); text_byte(8'hff, 1);
		text_byte("z", 0); text_byte(0, 1);
		drain();
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin send_idle = 57; recv_idle = 28; end
			if (phase == 2) begin send_idle = 0; recv_idle = 0; end
			for (int t = 0; t < 3; t++) begin
				build_trie();
				random_text(85);
				drain();
			end
		end
		drain();
		if (sb.errors == 0 && sb.expq.size() == 0)
			$display("[trie_dictionary_word_matcher_top] OK");
		else
			$display("[trie_dictionary_word_matcher_top] ERROR");
		$finish;
	end
endmodule
